// File: src/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared constants, types and helper functions for the Hamming(39,32) codec.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

    localparam int DATA_W = 32;
    localparam int PAR_W  = 7;
    localparam int CODE_W = DATA_W + PAR_W;
    localparam int STAT_W = 2;

    // Input tdata: data_word, code_word, zero pad to whole bytes
    localparam int IN_RAW_W  = DATA_W + CODE_W;
    localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
    // Output tdata: code_out, syndrome, error_status, pad to whole bytes
    localparam int OUT_RAW_W  = CODE_W + PAR_W + STAT_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [PAR_W-1:0]  par_t;
    typedef logic [CODE_W-1:0] code_t;

    typedef enum logic {
        REQ_ENCODE = 1'b0,
        REQ_DECODE = 1'b1
    } req_type_t;

    typedef enum logic [STAT_W-1:0] {
        ST_NONE        = 2'd0,
        ST_CORRECTED   = 2'd1,
        ST_UNCORRECTED = 2'd2
    } err_status_t;

    // Result of one item, passed from the datapath to the output register
    typedef struct packed {
        code_t       code_out;
        par_t        syndrome;
        err_status_t error_status;
    } result_t;

    // Check pattern per data bit: pattern bit 6 is check row 0
    localparam par_t CHK_PAT [DATA_W] = '{
        7'h4F, 7'h4A, 7'h52, 7'h54, 7'h57, 7'h58, 7'h5B, 7'h5D,
        7'h23, 7'h25, 7'h26, 7'h29, 7'h2A, 7'h2C, 7'h31, 7'h34,
        7'h0E, 7'h0B, 7'h13, 7'h15, 7'h16, 7'h19, 7'h1A, 7'h1C,
        7'h62, 7'h64, 7'h67, 7'h68, 7'h6B, 7'h6D, 7'h70, 7'h75
    };

    // Reverse bit order so that bit i is check row i
    function automatic par_t rev_par(input par_t v);
        par_t r;
        for (int k = 0; k < PAR_W; k++) begin
            r[PAR_W-1-k] = v[k];
        end
        return r;
    endfunction

endpackage : hsc_pkg

`default_nettype wire

// File: src/hsc_parity.sv
// ----------------------------------------------------------------------------
// hsc_parity
// XOR tree folding the check pattern of every set data bit.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_parity (
    input  wire hsc_pkg::data_t data,
    output      hsc_pkg::par_t  pattern
);
    import hsc_pkg::*;

    always_comb
    begin
        pattern = '0;
        for (int k = 0; k < DATA_W; k++)
        begin
            if (data[k])
            begin
                pattern = pattern ^ CHK_PAT[k];
            end
        end
    end

endmodule : hsc_parity

`default_nettype wire

// File: src/hsc_correct.sv
// ----------------------------------------------------------------------------
// hsc_correct
// Match the syndrome against the check columns and flip the matching bit.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_correct (
    input  wire hsc_pkg::code_t   code_word,
    input  wire hsc_pkg::par_t    pattern,
    output      hsc_pkg::result_t result
);
    import hsc_pkg::*;

    par_t  syn;
    code_t flip;
    logic  syn_onehot;

    assign syn        = pattern ^ code_word[PAR_W-1:0];
    assign syn_onehot = (syn != '0) && ((syn & (syn - par_t'(1))) == '0);

    always_comb
    begin
        // parity columns: weight-one syndromes
        flip[PAR_W-1:0] = syn_onehot ? syn : '0;
        // data columns
        for (int k = 0; k < DATA_W; k++)
        begin
            flip[k+PAR_W] = (syn == CHK_PAT[k]);
        end
    end

    always_comb
    begin
        result.code_out = code_word ^ flip;
        result.syndrome = rev_par(syn);
        if (syn == '0)
        begin
            result.error_status = ST_NONE;
        end
        else if (flip != '0)
        begin
            result.error_status = ST_CORRECTED;
        end
        else
        begin
            result.error_status = ST_UNCORRECTED;
        end
    end

endmodule : hsc_correct

`default_nettype wire

// File: src/hamming_sec_39_32_codec.sv
// ----------------------------------------------------------------------------
// hamming_sec_39_32_codec
// Hamming(39,32) single-error-correcting encoder and decoder on one stream.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item is held in the input register, and the result
// register takes its result once that stage is free to load.
// Throughput: one item per cycle unless m_axis_tready stalls the output;
// the XOR tree and column match sit between the registers, no iteration.
// Reset: rst_n clears both stage valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hamming_sec_39_32_codec (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // slave side
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: data_word[31:0], code_word[70:32], zero pad [71]
    input  wire  [hsc_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // tuser: req_type[0] (0 encode, 1 decode)
    input  wire                                  s_axis_tuser,
    // master side
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // tdata: code_out[38:0], syndrome[45:39], error_status[47:46]
    output logic [hsc_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
    import hsc_pkg::*;

    // Input stage
    logic      in_valid_reg;
    req_type_t in_req_reg;
    data_t     in_data_reg;
    code_t     in_code_reg;

    // Result stage
    logic      out_valid_reg;
    result_t   out_res_reg;
    result_t   out_res_next;

    logic      out_take;   // result stage may load this cycle
    logic      in_take;    // input stage may load this cycle

    // The result stage loads when it is empty or its item leaves now;
    // the input stage loads when empty or when its item moves on.
    assign out_take      = !out_valid_reg || m_axis_tready;
    assign in_take       = !in_valid_reg || out_take;
    assign s_axis_tready = in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Hold the payload unless a new item arrives
    always_ff @(posedge clk)
    begin
        if (in_take && s_axis_tvalid)
        begin
            in_req_reg  <= req_type_t'(s_axis_tuser);
            in_data_reg <= s_axis_tdata[DATA_W-1:0];
            in_code_reg <= s_axis_tdata[DATA_W+CODE_W-1:DATA_W];
        end
    end

    // Datapath: one shared parity tree, fed by the data word when encoding
    // and by the received data bits when decoding.
    data_t   par_data;
    par_t    pattern;
    result_t dec_res;

    assign par_data = (in_req_reg == REQ_DECODE) ? in_code_reg[CODE_W-1:PAR_W]
                                                 : in_data_reg;

    hsc_parity u_parity (
        .data    (par_data),
        .pattern (pattern)
    );

    hsc_correct u_correct (
        .code_word (in_code_reg),
        .pattern   (pattern),
        .result    (dec_res)
    );

    always_comb
    begin
        if (in_req_reg == REQ_DECODE)
        begin
            out_res_next = dec_res;
        end
        else
        begin
            // encode: data above, parity below, no syndrome or status
            out_res_next.code_out     = {in_data_reg, pattern};
            out_res_next.syndrome     = '0;
            out_res_next.error_status = ST_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Advance the result only when a finished item moves across
    always_ff @(posedge clk)
    begin
        if (out_take && in_valid_reg)
        begin
            out_res_reg <= out_res_next;
        end
    end

    // Pack code_out in the lowest bits, then syndrome, then status
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_res_reg.error_status,
                                        out_res_reg.syndrome,
                                        out_res_reg.code_out});

endmodule : hamming_sec_39_32_codec

`default_nettype wire

// File: dv/hamming_sec_39_32_codec_tb.sv
// ----------------------------------------------------------------------------
// hamming_sec_39_32_codec_tb
// Stream-level test of the Hamming(39,32) codec. A directed table covers the
// field extremes, both operations, clean words, single parity and data bit
// errors and an uncorrectable syndrome. A random part follows: encodes, and
// decodes of clean, single-error, double-error and arbitrary words. Every
// result is checked against an in-bench model of the code, while the sender
// idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module hamming_sec_39_32_codec_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hsc_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int DRAIN_ITEM   = 600;   // hold the sender here until all results are in
    localparam int PRINT_CAP    = 40;

    // Check column of each data bit: column bit 6 is check row 0
    localparam par_t PARITY_COLUMN [DATA_W] = '{
        7'h4F, 7'h4A, 7'h52, 7'h54, 7'h57, 7'h58, 7'h5B, 7'h5D,
        7'h23, 7'h25, 7'h26, 7'h29, 7'h2A, 7'h2C, 7'h31, 7'h34,
        7'h0E, 7'h0B, 7'h13, 7'h15, 7'h16, 7'h19, 7'h1A, 7'h1C,
        7'h62, 7'h64, 7'h67, 7'h68, 7'h6B, 7'h6D, 7'h70, 7'h75
    };

    // One row of the directed table. When from_enc is set, the row's data is
    // encoded first and code is an error mask laid over the code word.
    typedef struct packed {
        req_type_t req;
        bit        from_enc;
        data_t     data;
        code_t     code;
        bit        known;
        result_t   want;
    } stim_row_t;

    localparam int DIR_ROWS = 19;
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        // encode: all-zero, all-one data, ignored code field, single-bit ends
        '{REQ_ENCODE, 1'b0, 32'h0000_0000, 39'h00_0000_0000, 1'b1,
          '{39'h00_0000_0000, 7'h00, ST_NONE}},
        '{REQ_ENCODE, 1'b0, 32'hFFFF_FFFF, 39'h7F_FFFF_FFFF, 1'b0, '0},
        '{REQ_ENCODE, 1'b0, 32'h0000_0000, 39'h7F_FFFF_FFFF, 1'b1,
          '{39'h00_0000_0000, 7'h00, ST_NONE}},
        '{REQ_ENCODE, 1'b0, 32'h0000_0001, 39'h00_0000_0000, 1'b1,
          '{39'h00_0000_00CF, 7'h00, ST_NONE}},
        '{REQ_ENCODE, 1'b0, 32'h8000_0000, 39'h55_5555_5555, 1'b1,
          '{39'h40_0000_0075, 7'h00, ST_NONE}},
        '{REQ_ENCODE, 1'b0, 32'hA5A5_5A5A, 39'h2A_AAAA_AAAA, 1'b0, '0},
        // decode: zero word, all-one word with all-one ignored data field
        '{REQ_DECODE, 1'b0, 32'hFFFF_FFFF, 39'h00_0000_0000, 1'b1,
          '{39'h00_0000_0000, 7'h00, ST_NONE}},
        '{REQ_DECODE, 1'b0, 32'hFFFF_FFFF, 39'h7F_FFFF_FFFF, 1'b0, '0},
        // weight-one syndromes: lowest and highest parity bit
        '{REQ_DECODE, 1'b0, 32'h0000_0000, 39'h00_0000_0001, 1'b1,
          '{39'h00_0000_0000, 7'h40, ST_CORRECTED}},
        '{REQ_DECODE, 1'b0, 32'h0000_0000, 39'h00_0000_0040, 1'b1,
          '{39'h00_0000_0000, 7'h01, ST_CORRECTED}},
        // syndromes matching the lowest and highest data column
        '{REQ_DECODE, 1'b0, 32'h0000_0000, 39'h00_0000_0080, 1'b1,
          '{39'h00_0000_0000, 7'h79, ST_CORRECTED}},
        '{REQ_DECODE, 1'b0, 32'h0000_0000, 39'h40_0000_0000, 1'b1,
          '{39'h00_0000_0000, 7'h57, ST_CORRECTED}},
        // syndrome matching no column: word passes unchanged
        '{REQ_DECODE, 1'b0, 32'h0000_0000, 39'h00_0000_0003, 1'b1,
          '{39'h00_0000_0003, 7'h60, ST_UNCORRECTED}},
        // encoded words with error masks laid over them
        '{REQ_DECODE, 1'b1, 32'hDEAD_BEEF, 39'h00_0000_0000, 1'b0, '0},
        '{REQ_DECODE, 1'b1, 32'hDEAD_BEEF, 39'h00_0010_0000, 1'b0, '0},
        '{REQ_DECODE, 1'b1, 32'hFFFF_FFFF, 39'h00_0000_0008, 1'b0, '0},
        '{REQ_DECODE, 1'b1, 32'h1234_5678, 39'h00_0000_0180, 1'b0, '0},
        '{REQ_DECODE, 1'b1, 32'h0000_0000, 39'h40_0000_0001, 1'b0, '0},
        '{REQ_DECODE, 1'b1, 32'hFFFF_FFFF, 39'h40_0000_0000, 1'b0, '0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: data_word[31:0], code_word[70:32], zero pad [71]
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // tuser: req_type[0]
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata: code_out[38:0], syndrome[45:39], error_status[47:46]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    result_t     expected_results [$];
    int          mismatch_count = 0;
    int          burst_left = 0;
    int          n_encode = 0;
    int          n_decode = 0;
    int          n_checked = 0;
    int          n_corrected = 0;
    int          n_uncorrectable = 0;
    int unsigned rx_cycle = 0;
    int          rx_hold = 0;

    hamming_sec_39_32_codec i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // XOR of the check columns of every set data bit
    function automatic par_t column_sum(input data_t d);
        par_t acc;
        acc = '0;
        for (int k = 0; k < DATA_W; k++)
        begin
            if (d[k])
                acc ^= PARITY_COLUMN[k];
        end
        return acc;
    endfunction

    // Reorder so that bit i carries check row i
    function automatic par_t mirror_rows(input par_t v);
        return {v[0], v[1], v[2], v[3], v[4], v[5], v[6]};
    endfunction

    function automatic result_t predict_codec(input req_type_t req, input data_t d,
                                              input code_t w);
        result_t res;
        par_t    s;
        res = '0;
        if (req == REQ_ENCODE)
        begin
            res.code_out = {d, column_sum(d)};
            return res;
        end
        s = column_sum(w[CODE_W-1:PAR_W]) ^ w[PAR_W-1:0];
        res.code_out = w;
        res.syndrome = mirror_rows(s);
        if (s != '0)
        begin
            res.error_status = ST_UNCORRECTED;
            if ((s & (s - 1'b1)) == '0)
            begin
                // weight one: a parity bit is wrong
                res.code_out = w ^ code_t'(s);
                res.error_status = ST_CORRECTED;
            end
            else
            begin
                // columns are distinct, so at most one data bit matches
                for (int k = 0; k < DATA_W; k++)
                begin
                    if (PARITY_COLUMN[k] == s)
                    begin
                        res.code_out[k+PAR_W] = ~w[k+PAR_W];
                        res.error_status = ST_CORRECTED;
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("ERROR %0t ns: %s got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Present one item and hold it until accepted; leave tvalid high so that
    // a following item can go out back to back.
    task automatic send_item(input req_type_t req, input data_t d, input code_t w,
                             input bit known, input result_t want);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {1'b0, w, d};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.insert(expected_results.size(),
                                known ? want : predict_codec(req, d, w));
        if (req == REQ_ENCODE)
            n_encode++;
        else
            n_decode++;
    endtask

    // Bursts of random length, separated by random gaps (sometimes none)
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 23);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop tvalid and hold until every expected result has arrived
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Receiver: cycle through always-ready, a fixed duty pattern, coin flips
    // and long stall runs in turn.
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle >> 8) % 4)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ((rx_cycle % 7) < 4);
            2: m_axis_tready <= ($urandom_range(0, 1) == 1);
            default:
            begin
                if (rx_hold > 0)
                    rx_hold <= rx_hold - 1;
                else
                begin
                    m_axis_tready <= ~m_axis_tready;
                    rx_hold <= $urandom_range(0, 15);
                end
            end
        endcase
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result, tdata", 64'(m_axis_tdata), '0);
            else
            begin
                want = expected_results.pop_front();
                n_checked++;
                if (m_axis_tdata[38:0] !== want.code_out)
                    report_mismatch("code_out", 64'(m_axis_tdata[38:0]),
                                    64'(want.code_out));
                if (m_axis_tdata[45:39] !== want.syndrome)
                    report_mismatch("syndrome", 64'(m_axis_tdata[45:39]),
                                    64'(want.syndrome));
                if (m_axis_tdata[47:46] !== want.error_status)
                    report_mismatch("error_status", 64'(m_axis_tdata[47:46]),
                                    64'(want.error_status));
                if (want.error_status == ST_CORRECTED)
                    n_corrected++;
                if (want.error_status == ST_UNCORRECTED)
                    n_uncorrectable++;
            end
        end
    end

    initial
    begin
        stim_row_t row;
        result_t   enc;
        code_t     word;
        data_t     d;
        int        pick;
        int        pos_a;
        int        pos_b;
        req_type_t req;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIR_TABLE[i];
            word = row.code;
            if (row.from_enc)
            begin
                enc  = predict_codec(REQ_ENCODE, row.data, '0);
                word = enc.code_out ^ row.code;
            end
            send_item(row.req, row.data, word, row.known, row.want);
            pace_sender();
        end
        hold_until_drained();

        // Random part: mostly encoded words with few or no errors on top
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == DRAIN_ITEM)
                hold_until_drained();
            d    = $urandom();
            word = code_t'({$urandom(), $urandom()});
            pick = $urandom_range(0, 99);
            req  = REQ_DECODE;
            if (pick < 30)
                req = REQ_ENCODE;
            else if (pick < 86)
            begin
                enc  = predict_codec(REQ_ENCODE, d, '0);
                word = enc.code_out;
                pos_a = $urandom_range(0, CODE_W - 1);
                pos_b = $urandom_range(0, CODE_W - 1);
                if (pick >= 44)
                    word[pos_a] = ~word[pos_a];
                if (pick >= 72)
                    word[pos_b] = ~word[pos_b];
                d = $urandom();   // the data field is ignored on decode
            end
            send_item(req, d, word, 1'b0, '0);
            pace_sender();
        end
        hold_until_drained();
        repeat (8) @(posedge clk);

        $display("Summary: %0d encode and %0d decode items sent, %0d results checked",
                 n_encode, n_decode, n_checked);
        $display("Summary: %0d single-bit corrections, %0d uncorrectable words",
                 n_corrected, n_uncorrectable);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #(5_000_000);
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
